// File: hdl/fbb_pkg.sv
// ----------------------------------------------------------------------------
// fbb_pkg
// Shared types and constants of the foreground bounding box block: register
// indexes, register widths, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fbb_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH      = 3'd0,
    CFG_IMAGE_HEIGHT     = 3'd1,
    CFG_CHANNEL_COUNT    = 3'd2,
    CFG_WHITE_BACKGROUND = 3'd3,
    CFG_PADDING          = 3'd4,
    CFG_MAKE_SQUARE      = 3'd5
  } fbb_cfg_idx_e;

  // Register widths
  localparam int unsigned SizeRegW = 12;
  localparam int unsigned ChanCntW = 3;
  localparam int unsigned PadW     = 10;

  // Pixel and result field widths
  localparam int unsigned ChanW    = 8;
  localparam int unsigned BoxPosW  = 11;
  localparam int unsigned BoxSizeW = 12;

  // Channel count codes that produce foreground
  localparam logic [ChanCntW-1:0] ChanOne   = 3'd1;
  localparam logic [ChanCntW-1:0] ChanThree = 3'd3;
  localparam logic [ChanCntW-1:0] ChanFour  = 3'd4;

  // Background levels
  localparam logic [ChanW-1:0] BgBlack = 8'd0;
  localparam logic [ChanW-1:0] BgWhite = 8'd255;

  // Register reset values
  localparam logic [SizeRegW-1:0] RstImageWidth  = 12'd640;
  localparam logic [SizeRegW-1:0] RstImageHeight = 12'd480;
  localparam logic [ChanCntW-1:0] RstChanCount   = 3'd1;

  typedef struct packed {
    logic [SizeRegW-1:0] image_width;
    logic [SizeRegW-1:0] image_height;
    logic [ChanCntW-1:0] channel_count;
    logic                white_background;
    logic [PadW-1:0]     padding;
    logic                make_square;
  } fbb_cfg_t;

endpackage

`default_nettype wire

// File: hdl/fbb_pixel_track.sv
// ----------------------------------------------------------------------------
// fbb_pixel_track
// Registers each pixel, classifies it as foreground, steps the raster
// counters and keeps the extreme foreground rows and columns. At the last
// pixel of a frame it hands the raw extremes on as one record.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_pixel_track #(
  parameter int unsigned CW  = 11,  // column index width
  parameter int unsigned RW  = 11,  // row index width
  parameter int unsigned WSZ = 12,  // effective width value width
  parameter int unsigned HSZ = 12   // effective height value width
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbb_pkg::fbb_cfg_t             cfg_i,
  input  wire logic [WSZ-1:0]                eff_width_i,
  input  wire logic [HSZ-1:0]                eff_height_i,
  // pixel request
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fbb_pkg::ChanW-1:0]     chan0_i,
  input  wire logic [fbb_pkg::ChanW-1:0]     chan1_i,
  input  wire logic [fbb_pkg::ChanW-1:0]     chan2_i,
  input  wire logic [fbb_pkg::ChanW-1:0]     chan3_i,
  // frame record request
  output logic                               rec_valid_o,
  input  wire logic                          rec_ready_i,
  output logic [RW-1:0]                      rec_first_row_o,
  output logic [RW-1:0]                      rec_last_row_o,
  output logic [CW-1:0]                      rec_first_col_o,
  output logic [CW-1:0]                      rec_last_col_o,
  output logic                               rec_found_o
);

  // Pixel input register
  logic                      px_valid_q;
  logic [fbb_pkg::ChanW-1:0] px_c0_q, px_c1_q, px_c2_q, px_c3_q;

  // Raster and extreme tracking state
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [RW-1:0] first_row_q, first_row_d, first_row_upd;
  logic [RW-1:0] last_row_q, last_row_d, last_row_upd;
  logic [CW-1:0] first_col_q, first_col_d, first_col_upd;
  logic [CW-1:0] last_col_q, last_col_d, last_col_upd;
  logic          found_q, found_d, found_upd;

  // Frame record register
  logic          rec_valid_q;
  logic [RW-1:0] rec_first_row_q, rec_last_row_q;
  logic [CW-1:0] rec_first_col_q, rec_last_col_q;
  logic          rec_found_q;

  logic                      fg;
  logic [fbb_pkg::ChanW-1:0] bg;
  logic [WSZ-1:0]            width_m1;
  logic [HSZ-1:0]            height_m1;
  logic                      row_end, frame_end;
  logic                      rec_free, px_fire, in_fire;

  // Classify the held pixel
  always_comb begin
    bg = cfg_i.white_background ? fbb_pkg::BgWhite : fbb_pkg::BgBlack;
    case (cfg_i.channel_count)
      fbb_pkg::ChanOne:   fg = (px_c0_q != bg);
      fbb_pkg::ChanThree: fg = (px_c0_q != bg) || (px_c1_q != bg) || (px_c2_q != bg);
      fbb_pkg::ChanFour:  fg = (px_c0_q != bg) || (px_c1_q != bg) || (px_c2_q != bg) ||
                               (px_c3_q != bg);
      default:            fg = 1'b0;
    endcase
  end

  // Fold the pixel into the extremes
  always_comb begin
    first_row_upd = (fg && !found_q) ? row_q : first_row_q;
    last_row_upd  = fg ? row_q : last_row_q;
    first_col_upd = (fg && (col_q < first_col_q)) ? col_q : first_col_q;
    last_col_upd  = (fg && (col_q > last_col_q)) ? col_q : last_col_q;
    found_upd     = found_q | fg;
  end

  // Detect row and frame ends
  assign width_m1  = eff_width_i - WSZ'(1);
  assign height_m1 = eff_height_i - HSZ'(1);
  assign row_end   = ((WSZ+1)'(col_q) >= (WSZ+1)'(width_m1));
  assign frame_end = row_end && ((HSZ+1)'(row_q) >= (HSZ+1)'(height_m1));

  // Handshakes: the pixel stage only waits when it closes a frame
  assign rec_free   = !rec_valid_q || rec_ready_i;
  assign px_fire    = px_valid_q && (!frame_end || rec_free);
  assign in_ready_o = !px_valid_q || px_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Next tracking state
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    first_row_d = first_row_q;
    last_row_d  = last_row_q;
    first_col_d = first_col_q;
    last_col_d  = last_col_q;
    found_d     = found_q;
    if (px_fire) begin
      if (frame_end) begin
        col_d       = '0;
        row_d       = '0;
        first_row_d = '0;
        last_row_d  = '0;
        first_col_d = '1;
        last_col_d  = '0;
        found_d     = 1'b0;
      end else begin
        first_row_d = first_row_upd;
        last_row_d  = last_row_upd;
        first_col_d = first_col_upd;
        last_col_d  = last_col_upd;
        found_d     = found_upd;
        if (row_end) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_valid_q  <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      first_row_q <= '0;
      last_row_q  <= '0;
      first_col_q <= '1;
      last_col_q  <= '0;
      found_q     <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        px_valid_q <= in_valid_i;
      end
      col_q       <= col_d;
      row_q       <= row_d;
      first_row_q <= first_row_d;
      last_row_q  <= last_row_d;
      first_col_q <= first_col_d;
      last_col_q  <= last_col_d;
      found_q     <= found_d;
      if (rec_free) begin
        rec_valid_q <= px_fire && frame_end;
      end
    end
  end

  // Hold pixel and record payloads
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_c0_q <= chan0_i;
      px_c1_q <= chan1_i;
      px_c2_q <= chan2_i;
      px_c3_q <= chan3_i;
    end
    if (px_fire && frame_end) begin
      rec_first_row_q <= first_row_upd;
      rec_last_row_q  <= last_row_upd;
      rec_first_col_q <= first_col_upd;
      rec_last_col_q  <= last_col_upd;
      rec_found_q     <= found_upd;
    end
  end

  assign rec_valid_o     = rec_valid_q;
  assign rec_first_row_o = rec_first_row_q;
  assign rec_last_row_o  = rec_last_row_q;
  assign rec_first_col_o = rec_first_col_q;
  assign rec_last_col_o  = rec_last_col_q;
  assign rec_found_o     = rec_found_q;

endmodule

`default_nettype wire

// File: hdl/fbb_box_calc.sv
// ----------------------------------------------------------------------------
// fbb_box_calc
// Turns a frame record into the final box over a short pipeline: widen the
// extremes, add padding, square, clamp into the image, trim the far edges.
// The last stage is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_box_calc #(
  parameter int unsigned CW  = 11,
  parameter int unsigned RW  = 11,
  parameter int unsigned WSZ = 12,
  parameter int unsigned HSZ = 12,
  parameter int unsigned SW  = 14   // signed working width
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbb_pkg::fbb_cfg_t             cfg_i,
  input  wire logic [WSZ-1:0]                eff_width_i,
  input  wire logic [HSZ-1:0]                eff_height_i,
  // frame record request
  input  wire logic                          rec_valid_i,
  output logic                               rec_ready_o,
  input  wire logic [RW-1:0]                 rec_first_row_i,
  input  wire logic [RW-1:0]                 rec_last_row_i,
  input  wire logic [CW-1:0]                 rec_first_col_i,
  input  wire logic [CW-1:0]                 rec_last_col_i,
  input  wire logic                          rec_found_i,
  // box request
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [fbb_pkg::BoxPosW-1:0]        box_x_o,
  output logic [fbb_pkg::BoxPosW-1:0]        box_y_o,
  output logic [fbb_pkg::BoxSizeW-1:0]       box_width_o,
  output logic [fbb_pkg::BoxSizeW-1:0]       box_height_o
);

  logic signed [SW-1:0] img_w, img_h, pad, pad2;

  // Stage valids and readies
  logic v2_q, v3_q, v4_q, v5_q, vo_q;
  logic r2, r3, r4, r5, ro;

  // Stage payloads
  logic signed [SW-1:0] top_q, bottom_q, left_q, right_q;
  logic signed [SW-1:0] x3_q, y3_q, w3_q, h3_q;
  logic signed [SW-1:0] x4_q, y4_q, w4_q, h4_q;
  logic signed [SW-1:0] x5_q, y5_q, w5_q, h5_q;
  logic signed [SW-1:0] xo_q, yo_q, wo_q, ho_q;

  logic signed [SW-1:0] top_d, bottom_d, left_d, right_d;
  logic signed [SW-1:0] x4_d, y4_d, w4_d, h4_d, diff, ndiff;
  logic signed [SW-1:0] x5_d, y5_d, w5_d, h5_d;
  logic signed [SW-1:0] ex, ey, wo_d, ho_d;
  logic signed [SW-1:0] fr, lr, fc, lc;

  assign img_w = SW'(eff_width_i);
  assign img_h = SW'(eff_height_i);
  assign pad   = SW'(cfg_i.padding);
  assign pad2  = SW'({cfg_i.padding, 1'b0});

  // Stall chain from the result register back to the record input
  assign ro          = !vo_q || out_ready_i;
  assign r5          = !v5_q || ro;
  assign r4          = !v4_q || r5;
  assign r3          = !v3_q || r4;
  assign r2          = !v2_q || r3;
  assign rec_ready_o = r2;

  // Widen the extremes by one pixel inside the image; whole image if empty
  always_comb begin
    fr = SW'(rec_first_row_i);
    lr = SW'(rec_last_row_i);
    fc = SW'(rec_first_col_i);
    lc = SW'(rec_last_col_i);
    if (rec_found_i) begin
      top_d    = (fr > 0) ? fr - SW'(1) : fr;
      bottom_d = (lr < img_h - SW'(1)) ? lr + SW'(1) : lr;
      left_d   = (fc > 0) ? fc - SW'(1) : fc;
      right_d  = (lc < img_w - SW'(1)) ? lc + SW'(1) : lc;
    end else begin
      top_d    = '0;
      bottom_d = img_h - SW'(1);
      left_d   = '0;
      right_d  = img_w - SW'(1);
    end
  end

  // Grow the shorter side; the shift halves a non-negative difference
  always_comb begin
    x4_d  = x3_q;
    y4_d  = y3_q;
    w4_d  = w3_q;
    h4_d  = h3_q;
    diff  = h3_q - w3_q;
    ndiff = w3_q - h3_q;
    if (cfg_i.make_square) begin
      if (diff > 0) begin
        x4_d = x3_q - (diff >>> 1);
        w4_d = w3_q + diff;
      end else begin
        y4_d = y3_q - (ndiff >>> 1);
        h4_d = h3_q + ndiff;
      end
    end
  end

  // Clamp the corner into the image and the sizes to zero
  always_comb begin
    x5_d = (x4_q < 0) ? '0 : ((x4_q >= img_w) ? img_w - SW'(1) : x4_q);
    y5_d = (y4_q < 0) ? '0 : ((y4_q >= img_h) ? img_h - SW'(1) : y4_q);
    w5_d = (w4_q < 0) ? '0 : w4_q;
    h5_d = (h4_q < 0) ? '0 : h4_q;
  end

  // Trim a box that runs past the right or bottom edge
  always_comb begin
    ex   = x5_q + w5_q;
    ey   = y5_q + h5_q;
    wo_d = (ex > img_w) ? img_w - x5_q - SW'(1) : w5_q;
    ho_d = (ey > img_h) ? img_h - y5_q - SW'(1) : h5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (r2) v2_q <= rec_valid_i;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
      if (ro) vo_q <= v5_q;
    end
  end

  // Advance payloads
  always_ff @(posedge clk_i) begin
    if (r2 && rec_valid_i) begin
      top_q    <= top_d;
      bottom_q <= bottom_d;
      left_q   <= left_d;
      right_q  <= right_d;
    end
    if (r3 && v2_q) begin
      x3_q <= left_q - pad;
      y3_q <= top_q - pad;
      w3_q <= right_q - left_q + pad2;
      h3_q <= bottom_q - top_q + pad2;
    end
    if (r4 && v3_q) begin
      x4_q <= x4_d;
      y4_q <= y4_d;
      w4_q <= w4_d;
      h4_q <= h4_d;
    end
    if (r5 && v4_q) begin
      x5_q <= x5_d;
      y5_q <= y5_d;
      w5_q <= w5_d;
      h5_q <= h5_d;
    end
    if (ro && v5_q) begin
      xo_q <= x5_q;
      yo_q <= y5_q;
      wo_q <= wo_d;
      ho_q <= ho_d;
    end
  end

  assign out_valid_o  = vo_q;
  assign box_x_o      = xo_q[fbb_pkg::BoxPosW-1:0];
  assign box_y_o      = yo_q[fbb_pkg::BoxPosW-1:0];
  assign box_width_o  = wo_q[fbb_pkg::BoxSizeW-1:0];
  assign box_height_o = ho_q[fbb_pkg::BoxSizeW-1:0];

endmodule

`default_nettype wire

// File: hdl/foreground_bounding_box.sv
// ----------------------------------------------------------------------------
// foreground_bounding_box
// Finds the bounding box of the foreground pixels of a raster-order image
// and reports it, padded, optionally squared and clamped, once per frame.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    chan0_i .. chan3_i
//  out      output     out_valid_o / out_ready_i  box_x_o, box_y_o,
//                                                 box_width_o, box_height_o
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One pixel is taken every clock while in_ready_o is high. After the
//  last pixel of a frame enters the pixel register, the box passes the
//  frame record, then five box stages ending in the result register.
//  Reset clears the raster counters, the tracked extremes and all valids
//  and loads the register defaults. No clearing pass follows reset.
//  A stalled result holds the box pipeline; pixels keep flowing until a
//  frame end finds the record stage full.
//
`default_nettype none

module foreground_bounding_box #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [fbb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [fbb_pkg::CfgDataW-1:0]      cfg_data_i,
  // pixels
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [fbb_pkg::ChanW-1:0]         chan0_i,
  input  wire logic [fbb_pkg::ChanW-1:0]         chan1_i,
  input  wire logic [fbb_pkg::ChanW-1:0]         chan2_i,
  input  wire logic [fbb_pkg::ChanW-1:0]         chan3_i,
  // box results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [fbb_pkg::BoxPosW-1:0]            box_x_o,
  output logic [fbb_pkg::BoxPosW-1:0]            box_y_o,
  output logic [fbb_pkg::BoxSizeW-1:0]           box_width_o,
  output logic [fbb_pkg::BoxSizeW-1:0]           box_height_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WSZ = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSZ = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SZW = (WSZ > HSZ) ? WSZ : HSZ;
  // room for twice the padding and a squared side past the image
  localparam int unsigned SW  = ((SZW > fbb_pkg::PadW + 1) ? SZW : fbb_pkg::PadW + 1) + 3;

  fbb_pkg::fbb_cfg_t cfg_q;
  logic [WSZ-1:0]    eff_width;
  logic [HSZ-1:0]    eff_height;

  logic          rec_valid, rec_ready, rec_found;
  logic [RW-1:0] rec_first_row, rec_last_row;
  logic [CW-1:0] rec_first_col, rec_last_col;

  // Register writes; unknown indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= fbb_pkg::RstImageWidth;
      cfg_q.image_height     <= fbb_pkg::RstImageHeight;
      cfg_q.channel_count    <= fbb_pkg::RstChanCount;
      cfg_q.white_background <= 1'b0;
      cfg_q.padding          <= '0;
      cfg_q.make_square      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fbb_pkg::CFG_IMAGE_WIDTH:      cfg_q.image_width   <= cfg_data_i;
        fbb_pkg::CFG_IMAGE_HEIGHT:     cfg_q.image_height  <= cfg_data_i;
        fbb_pkg::CFG_CHANNEL_COUNT:
          cfg_q.channel_count <= cfg_data_i[fbb_pkg::ChanCntW-1:0];
        fbb_pkg::CFG_WHITE_BACKGROUND: cfg_q.white_background <= cfg_data_i[0];
        fbb_pkg::CFG_PADDING:
          cfg_q.padding <= cfg_data_i[fbb_pkg::PadW-1:0];
        fbb_pkg::CFG_MAKE_SQUARE:      cfg_q.make_square <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective image size: zero reads as one, large values saturate
  always_comb begin
    if (cfg_q.image_width == '0) begin
      eff_width = WSZ'(1);
    end else if (32'(cfg_q.image_width) > 32'(MAX_WIDTH)) begin
      eff_width = WSZ'(MAX_WIDTH);
    end else begin
      eff_width = WSZ'(cfg_q.image_width);
    end
    if (cfg_q.image_height == '0) begin
      eff_height = HSZ'(1);
    end else if (32'(cfg_q.image_height) > 32'(MAX_HEIGHT)) begin
      eff_height = HSZ'(MAX_HEIGHT);
    end else begin
      eff_height = HSZ'(cfg_q.image_height);
    end
  end

  fbb_pixel_track #(
    .CW  (CW),
    .RW  (RW),
    .WSZ (WSZ),
    .HSZ (HSZ)
  ) u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .eff_width_i     (eff_width),
    .eff_height_i    (eff_height),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .chan0_i         (chan0_i),
    .chan1_i         (chan1_i),
    .chan2_i         (chan2_i),
    .chan3_i         (chan3_i),
    .rec_valid_o     (rec_valid),
    .rec_ready_i     (rec_ready),
    .rec_first_row_o (rec_first_row),
    .rec_last_row_o  (rec_last_row),
    .rec_first_col_o (rec_first_col),
    .rec_last_col_o  (rec_last_col),
    .rec_found_o     (rec_found)
  );

  fbb_box_calc #(
    .CW  (CW),
    .RW  (RW),
    .WSZ (WSZ),
    .HSZ (HSZ),
    .SW  (SW)
  ) u_box (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .eff_width_i     (eff_width),
    .eff_height_i    (eff_height),
    .rec_valid_i     (rec_valid),
    .rec_ready_o     (rec_ready),
    .rec_first_row_i (rec_first_row),
    .rec_last_row_i  (rec_last_row),
    .rec_first_col_i (rec_first_col),
    .rec_last_col_i  (rec_last_col),
    .rec_found_i     (rec_found),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .box_x_o         (box_x_o),
    .box_y_o         (box_y_o),
    .box_width_o     (box_width_o),
    .box_height_o    (box_height_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the foreground bounding box block. It sends short
// directed frames first, then random phases of small frames with blobs of
// foreground, one long row and one long column, and a burst of 1x1 frames
// against a stalled result port. Each box must match a given or predicted box.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxSize     = 2048;
  localparam int unsigned RandItems   = 470;
  localparam int unsigned LongSide    = 64;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned HoldCycles  = 300;

  typedef logic [fbb_pkg::ChanW-1:0]    chan_t;
  typedef logic [fbb_pkg::CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [fbb_pkg::CfgDataW-1:0] cfg_data_t;
  typedef logic [fbb_pkg::ChanCntW-1:0] chan_cnt_t;
  typedef logic [fbb_pkg::PadW-1:0]     pad_t;

  // Register indexes the block does not implement
  localparam cfg_idx_t CfgIdxSpareLo = 3'd6;
  localparam cfg_idx_t CfgIdxSpareHi = 3'd7;
  // Channel count that never yields foreground
  localparam chan_cnt_t ChanTwo = 3'd2;

  typedef chan_t pixel_t [4];

  typedef struct packed {
    logic [fbb_pkg::BoxPosW-1:0]  x;
    logic [fbb_pkg::BoxPosW-1:0]  y;
    logic [fbb_pkg::BoxSizeW-1:0] w;
    logic [fbb_pkg::BoxSizeW-1:0] h;
  } box_t;

  typedef enum logic [1:0] {STEP_WRITE, STEP_PIXEL, STEP_PIXEL_BOX} step_kind_e;
  typedef enum logic [1:0] {IDLE_SRC_LIGHT, IDLE_SRC_HEAVY, IDLE_NONE} idle_mode_e;

  typedef struct {
    step_kind_e kind;
    cfg_idx_t   idx;
    cfg_data_t  data;
    pixel_t     px;
    box_t       box;
  } step_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  cfg_idx_t                      cfg_index_i;
  cfg_data_t                     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  chan_t                         chan0_i;
  chan_t                         chan1_i;
  chan_t                         chan2_i;
  chan_t                         chan3_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [fbb_pkg::BoxPosW-1:0]   box_x_o;
  logic [fbb_pkg::BoxPosW-1:0]   box_y_o;
  logic [fbb_pkg::BoxSizeW-1:0]  box_width_o;
  logic [fbb_pkg::BoxSizeW-1:0]  box_height_o;

  // Predictor copy of the registers and the frame tracking state
  fbb_pkg::fbb_cfg_t           shadow;
  logic [fbb_pkg::BoxPosW-1:0] col_cnt;
  logic [fbb_pkg::BoxPosW-1:0] row_cnt;
  logic [fbb_pkg::BoxPosW-1:0] top_row;
  logic [fbb_pkg::BoxPosW-1:0] bot_row;
  logic [fbb_pkg::BoxPosW-1:0] left_col;
  logic [fbb_pkg::BoxPosW-1:0] right_col;
  logic                        seen_fg;

  box_t        pending_boxes[$];
  step_t       plan[$];
  int unsigned errors;
  int unsigned pixels_sent;
  int unsigned boxes_checked;
  int unsigned reg_writes;
  int unsigned phases;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_req;
  int unsigned hold_served;

  foreground_bounding_box dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .chan0_i      (chan0_i),
    .chan1_i      (chan1_i),
    .chan2_i      (chan2_i),
    .chan3_i      (chan3_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .box_x_o      (box_x_o),
    .box_y_o      (box_y_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t ns", what, got, want, $time);
  endtask

  task automatic set_idle_mode(input idle_mode_e m);
    case (m)
      IDLE_SRC_LIGHT: begin
        src_idle_pct  = 18;
        sink_idle_pct = 74;
      end
      IDLE_SRC_HEAVY: begin
        src_idle_pct  = 74;
        sink_idle_pct = 18;
      end
      default: begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_size(input logic [fbb_pkg::SizeRegW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxSize) return MaxSize;
    return 32'(v);
  endfunction

  function automatic void clear_frame_state();
    col_cnt   = '0;
    row_cnt   = '0;
    top_row   = '0;
    bot_row   = '0;
    left_col  = '1;
    right_col = '0;
    seen_fg   = 1'b0;
  endfunction

  function automatic bit pixel_is_fg(input pixel_t px);
    chan_t bg;
    int    used;
    bg = shadow.white_background ? fbb_pkg::BgWhite : fbb_pkg::BgBlack;
    case (shadow.channel_count)
      fbb_pkg::ChanOne:   used = 1;
      fbb_pkg::ChanThree: used = 3;
      fbb_pkg::ChanFour:  used = 4;
      default:            used = 0;
    endcase
    for (int i = 0; i < used; i++)
      if (px[i] != bg) return 1'b1;
    return 1'b0;
  endfunction

  // Widen, pad, square and clamp the tracked extremes
  function automatic box_t frame_box(input int wd, input int ht);
    int   top, bottom, left, right, x, y, w, h, d, pad, fr, lr, fc, lc;
    box_t b;
    pad    = int'(shadow.padding);
    top    = 0;
    bottom = ht - 1;
    left   = 0;
    right  = wd - 1;
    if (seen_fg) begin
      fr     = int'(top_row);
      lr     = int'(bot_row);
      fc     = int'(left_col);
      lc     = int'(right_col);
      top    = (fr > 0) ? fr - 1 : fr;
      bottom = (lr < ht - 1) ? lr + 1 : lr;
      left   = (fc > 0) ? fc - 1 : fc;
      right  = (lc < wd - 1) ? lc + 1 : lc;
    end
    x = left - pad;
    y = top - pad;
    w = right - left + 2 * pad;
    h = bottom - top + 2 * pad;
    if (shadow.make_square) begin
      d = h - w;
      if (d > 0) begin
        x -= d / 2;
        w += d;
      end else begin
        y -= (-d) / 2;
        h -= d;
      end
    end
    if (x < 0) x = 0;
    if (x >= wd) x = wd - 1;
    if (y < 0) y = 0;
    if (y >= ht) y = ht - 1;
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    if (x + w > wd) w -= x + w - wd + 1;
    if (y + h > ht) h -= y + h - ht + 1;
    b.x = x[fbb_pkg::BoxPosW-1:0];
    b.y = y[fbb_pkg::BoxPosW-1:0];
    b.w = w[fbb_pkg::BoxSizeW-1:0];
    b.h = h[fbb_pkg::BoxSizeW-1:0];
    return b;
  endfunction

  // Advance the raster position; returns 1 with the box at a frame end
  function automatic bit track_pixel(input pixel_t px, output box_t box);
    int unsigned wd, ht;
    wd  = eff_size(shadow.image_width);
    ht  = eff_size(shadow.image_height);
    box = '0;
    if (pixel_is_fg(px)) begin
      if (!seen_fg) top_row = row_cnt;
      bot_row = row_cnt;
      if (col_cnt < left_col) left_col = col_cnt;
      if (col_cnt > right_col) right_col = col_cnt;
      seen_fg = 1'b1;
    end
    if (col_cnt >= wd - 1) begin
      col_cnt = '0;
      if (row_cnt >= ht - 1) begin
        box = frame_box(wd, ht);
        clear_frame_state();
        return 1'b1;
      end
      row_cnt++;
    end else begin
      col_cnt++;
    end
    return 1'b0;
  endfunction

  // ------------------------------------------------------------------ drivers

  // Entered and left at a falling edge; keeps valid high after acceptance
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fbb_pkg::CFG_IMAGE_WIDTH:
        shadow.image_width = data[fbb_pkg::SizeRegW-1:0];
      fbb_pkg::CFG_IMAGE_HEIGHT:
        shadow.image_height = data[fbb_pkg::SizeRegW-1:0];
      fbb_pkg::CFG_CHANNEL_COUNT:
        shadow.channel_count = data[fbb_pkg::ChanCntW-1:0];
      fbb_pkg::CFG_WHITE_BACKGROUND: shadow.white_background = data[0];
      fbb_pkg::CFG_PADDING:          shadow.padding = data[fbb_pkg::PadW-1:0];
      fbb_pkg::CFG_MAKE_SQUARE:      shadow.make_square = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  // Offer one pixel, with a random gap first; record the box it may close
  task automatic push_pixel(input pixel_t px, input bit given, input box_t given_box);
    box_t b;
    cfg_valid_i = 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    chan0_i    = px[0];
    chan1_i    = px[1];
    chan2_i    = px[2];
    chan3_i    = px[3];
    do @(posedge clk_i); while (!in_ready_o);
    if (track_pixel(px, b)) pending_boxes.push_back(given ? given_box : b);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every box is out and the pipeline has emptied
  task automatic settle();
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Stream pixels with a rectangular blob of foreground and sparse noise
  task automatic paint_pixels(input int unsigned n);
    int unsigned wd, ht, c_lo, c_hi, r_lo, r_hi, blob_pct, noise_pct;
    pixel_t      px;
    chan_t       bg;
    bit          in_blob;
    wd        = eff_size(shadow.image_width);
    ht        = eff_size(shadow.image_height);
    c_lo      = $urandom_range(0, wd - 1);
    c_hi      = $urandom_range(c_lo, wd - 1);
    r_lo      = $urandom_range(0, ht - 1);
    r_hi      = $urandom_range(r_lo, ht - 1);
    blob_pct  = ($urandom_range(9) == 0) ? 0 : 60;
    noise_pct = (blob_pct == 0) ? 0 : 2;
    repeat (n) begin
      bg      = shadow.white_background ? fbb_pkg::BgWhite : fbb_pkg::BgBlack;
      in_blob = col_cnt >= c_lo && col_cnt <= c_hi && row_cnt >= r_lo && row_cnt <= r_hi;
      px      = '{default: bg};
      if ($urandom_range(99) < (in_blob ? blob_pct : noise_pct)) begin
        px[$urandom_range(0, 3)] = chan_t'($urandom);
        if ($urandom_range(1)) foreach (px[k]) px[k] = chan_t'($urandom);
      end else if ($urandom_range(3) == 0) begin
        // disturb channels that a count below four ignores
        px[3] = chan_t'($urandom);
        if (shadow.channel_count == fbb_pkg::ChanOne) begin
          px[1] = chan_t'($urandom);
          px[2] = chan_t'($urandom);
        end
      end
      push_pixel(px, 1'b0, '0);
    end
  endtask

  // Rewrite a random subset of the registers, junk in the unused data bits
  task automatic shuffle_config();
    cfg_data_t noise;
    chan_cnt_t chans;
    pad_t      pad;
    noise = cfg_data_t'($urandom);
    if ($urandom_range(3) != 0)
      write_reg(fbb_pkg::CFG_IMAGE_WIDTH,
                cfg_data_t'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8)));
    if ($urandom_range(3) != 0)
      write_reg(fbb_pkg::CFG_IMAGE_HEIGHT,
                cfg_data_t'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6)));
    if ($urandom_range(1)) begin
      case ($urandom_range(0, 7))
        0, 1:    chans = fbb_pkg::ChanOne;
        2, 3:    chans = fbb_pkg::ChanThree;
        4, 5:    chans = fbb_pkg::ChanFour;
        default: chans = chan_cnt_t'($urandom);
      endcase
      write_reg(fbb_pkg::CFG_CHANNEL_COUNT,
                {noise[fbb_pkg::CfgDataW-1:fbb_pkg::ChanCntW], chans});
    end
    if ($urandom_range(2) == 0)
      write_reg(fbb_pkg::CFG_WHITE_BACKGROUND,
                {noise[fbb_pkg::CfgDataW-1:1], 1'($urandom_range(1))});
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(0, 9))
        6, 7:    pad = noise[fbb_pkg::PadW-1:0];
        8:       pad = '1;
        9:       pad = '0;
        default: pad = pad_t'($urandom_range(0, 3));
      endcase
      write_reg(fbb_pkg::CFG_PADDING, {noise[fbb_pkg::CfgDataW-1:fbb_pkg::PadW], pad});
    end
    if ($urandom_range(2) == 0)
      write_reg(fbb_pkg::CFG_MAKE_SQUARE,
                {noise[fbb_pkg::CfgDataW-1:1], 1'($urandom_range(1))});
    if ($urandom_range(7) == 0)
      write_reg($urandom_range(1) ? CfgIdxSpareLo : CfgIdxSpareHi, noise);
  endtask

  function automatic void plan_write(input cfg_idx_t idx, input cfg_data_t data);
    step_t s;
    s.kind = STEP_WRITE;
    s.idx  = idx;
    s.data = data;
    s.px   = '{default: fbb_pkg::BgBlack};
    s.box  = '0;
    plan.push_back(s);
  endfunction

  function automatic void plan_pixel(input pixel_t px, input bit given, input box_t box);
    step_t s;
    s.kind = given ? STEP_PIXEL_BOX : STEP_PIXEL;
    s.idx  = '0;
    s.data = '0;
    s.px   = px;
    s.box  = box;
    plan.push_back(s);
  endfunction

  // ------------------------------------------------------------------ sink

  // Drop ready at random, and for a long stretch when a hold is requested
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_served++;
      end
      out_ready_i = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each delivered box with the oldest pending one
  always @(posedge clk_i) begin
    box_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch("box with none pending, box_x", box_x_o, -1);
      end else begin
        want = pending_boxes.pop_front();
        boxes_checked++;
        if (box_x_o !== want.x) report_mismatch("box_x", box_x_o, want.x);
        if (box_y_o !== want.y) report_mismatch("box_y", box_y_o, want.y);
        if (box_width_o !== want.w) report_mismatch("box_width", box_width_o, want.w);
        if (box_height_o !== want.h) report_mismatch("box_height", box_height_o, want.h);
      end
    end
  end

  // ------------------------------------------------------------------ main

  initial begin
    int unsigned wd, ht, n, rand_px, guard;
    pixel_t      blank, bright;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    chan0_i       = '0;
    chan1_i       = '0;
    chan2_i       = '0;
    chan3_i       = '0;
    errors        = 0;
    pixels_sent   = 0;
    boxes_checked = 0;
    reg_writes    = 0;
    phases        = 0;
    hold_req      = 0;
    hold_served   = 0;
    rand_px       = 0;
    shadow.image_width      = fbb_pkg::RstImageWidth;
    shadow.image_height     = fbb_pkg::RstImageHeight;
    shadow.channel_count    = fbb_pkg::RstChanCount;
    shadow.white_background = 1'b0;
    shadow.padding          = '0;
    shadow.make_square      = 1'b0;
    clear_frame_state();
    set_idle_mode(IDLE_SRC_LIGHT);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    blank  = '{default: fbb_pkg::BgBlack};
    bright = '{default: fbb_pkg::BgWhite};

    // Zero sizes act as 1x1; unknown index is ignored
    plan_write(fbb_pkg::CFG_IMAGE_WIDTH, 12'd0);
    plan_write(fbb_pkg::CFG_IMAGE_HEIGHT, 12'd0);
    plan_write(CfgIdxSpareLo, 12'hFFF);
    plan_pixel(blank, 1'b1, '{11'd0, 11'd0, 12'd0, 12'd0});
    // Full padding and squaring still clamp to the single pixel
    plan_write(fbb_pkg::CFG_PADDING, 12'hFFF);
    plan_write(fbb_pkg::CFG_MAKE_SQUARE, 12'd1);
    plan_pixel(bright, 1'b1, '{11'd0, 11'd0, 12'd0, 12'd0});
    // White background, three channels: the fourth byte is ignored
    plan_write(fbb_pkg::CFG_IMAGE_WIDTH, 12'd2);
    plan_write(fbb_pkg::CFG_IMAGE_HEIGHT, 12'd2);
    plan_write(fbb_pkg::CFG_PADDING, 12'd0);
    plan_write(fbb_pkg::CFG_MAKE_SQUARE, 12'd0);
    plan_write(fbb_pkg::CFG_CHANNEL_COUNT, 12'(fbb_pkg::ChanThree));
    plan_write(fbb_pkg::CFG_WHITE_BACKGROUND, 12'd1);
    plan_pixel('{8'd255, 8'd255, 8'd255, 8'd0}, 1'b0, '0);
    plan_pixel(bright, 1'b0, '0);
    plan_pixel(bright, 1'b0, '0);
    plan_pixel('{8'd255, 8'd255, 8'd0, 8'd255}, 1'b1, '{11'd0, 11'd0, 12'd1, 12'd1});
    // Four channels: the fourth byte now counts
    plan_write(fbb_pkg::CFG_CHANNEL_COUNT, 12'(fbb_pkg::ChanFour));
    plan_pixel('{8'd255, 8'd255, 8'd255, 8'd0}, 1'b0, '0);
    plan_pixel(bright, 1'b0, '0);
    plan_pixel(bright, 1'b0, '0);
    plan_pixel(bright, 1'b0, '0);
    // Two channels never give foreground: whole image
    plan_write(fbb_pkg::CFG_CHANNEL_COUNT, 12'(ChanTwo));
    plan_write(fbb_pkg::CFG_IMAGE_HEIGHT, 12'd1);
    plan_pixel(blank, 1'b0, '0);
    plan_pixel(blank, 1'b1, '{11'd0, 11'd0, 12'd1, 12'd0});
    // Unused count seven, black background
    plan_write(fbb_pkg::CFG_CHANNEL_COUNT, 12'hFFF);
    plan_write(fbb_pkg::CFG_WHITE_BACKGROUND, 12'd0);
    plan_pixel(bright, 1'b0, '0);
    plan_pixel(bright, 1'b1, '{11'd0, 11'd0, 12'd1, 12'd0});
    // One lit center pixel in a padded, squared 3x3 frame
    plan_write(fbb_pkg::CFG_IMAGE_WIDTH, 12'd3);
    plan_write(fbb_pkg::CFG_IMAGE_HEIGHT, 12'd3);
    plan_write(fbb_pkg::CFG_PADDING, 12'd2);
    plan_write(fbb_pkg::CFG_MAKE_SQUARE, 12'd1);
    plan_write(fbb_pkg::CFG_CHANNEL_COUNT, 12'(fbb_pkg::ChanOne));
    for (int i = 0; i < 9; i++)
      plan_pixel((i == 4) ? pixel_t'{8'd200, 8'd0, 8'd0, 8'd0} : blank, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        if (i == 0 || plan[i-1].kind != STEP_WRITE) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_pixel(plan[i].px, plan[i].kind == STEP_PIXEL_BOX, plan[i].box);
      end
    end

    // Random phases; a phase may stop mid-frame so the next settings apply
    // to a partly scanned frame
    while (rand_px < RandItems) begin
      if (rand_px < RandItems / 3) set_idle_mode(IDLE_SRC_LIGHT);
      else if (rand_px < 2 * RandItems / 3) set_idle_mode(IDLE_SRC_HEAVY);
      else set_idle_mode(IDLE_NONE);
      settle();
      shuffle_config();
      wd = eff_size(shadow.image_width);
      ht = eff_size(shadow.image_height);
      n  = $urandom_range(1, 3) * wd * ht;
      if ($urandom_range(1)) n += $urandom_range(0, wd * ht - 1);
      paint_pixels(n);
      rand_px += n;
      phases++;
    end

    // Long frames: one wide row, one tall column
    set_idle_mode(IDLE_NONE);
    settle();
    write_reg(fbb_pkg::CFG_IMAGE_WIDTH, cfg_data_t'(LongSide));
    write_reg(fbb_pkg::CFG_IMAGE_HEIGHT, 12'd1);
    paint_pixels(LongSide - col_cnt);
    settle();
    write_reg(fbb_pkg::CFG_IMAGE_WIDTH, 12'd1);
    write_reg(fbb_pkg::CFG_IMAGE_HEIGHT, cfg_data_t'(LongSide));
    paint_pixels(LongSide - row_cnt);
    phases += 2;

    // Stall the result port while 1x1 frames keep coming, to back up the input
    settle();
    write_reg(fbb_pkg::CFG_IMAGE_WIDTH, 12'd1);
    write_reg(fbb_pkg::CFG_IMAGE_HEIGHT, 12'd1);
    hold_req++;
    paint_pixels(40);
    phases++;

    // Drain
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b0;
    guard       = 0;
    while (pending_boxes.size() != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (pending_boxes.size() != 0)
      report_mismatch("boxes never delivered", 0, pending_boxes.size());

    $display("Summary: %0d pixels in %0d phases, %0d boxes checked, %0d register writes",
             pixels_sent, phases, boxes_checked, reg_writes);
    $display("Summary: frames 1x1 to %0d long, all channel counts, both backgrounds, %s",
             LongSide, "padding to 1023, squaring, mid-frame size changes, output stall");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fbb_pkg.sv
hdl/fbb_pixel_track.sv
hdl/fbb_box_calc.sv
hdl/foreground_bounding_box.sv
tb/sv/tb_top.sv
